@@ design/gclp_pkg.sv @@
// Package with the shared types and constants of the G-code line field parser.
package gclp_pkg;

  typedef enum logic [2:0] {
    LET_NONE = 3'd0,
    LET_G    = 3'd1,
    LET_X    = 3'd2,
    LET_Y    = 3'd3,
    LET_Z    = 3'd4,
    LET_I    = 3'd5,
    LET_J    = 3'd6
  } letter_e;

  typedef enum logic [2:0] {
    CFG_SCALE = 3'd0,
    CFG_OFFX  = 3'd1,
    CFG_OFFY  = 3'd2,
    CFG_INITX = 3'd3,
    CFG_INITY = 3'd4
  } cfg_idx_e;

  localparam logic [39:0] INT_CAP = 40'hFF_FFFF_FFFF;
  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [3:0] MAX_GCMD = 4'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start_letter;
    letter_e letter;
    logic    set_neg;
    logic    neg_val;
    logic    int_digit;
    logic    frac_digit;
    logic [3:0] digit;
    logic    fin_start;
    logic    fin_step;
    logic [2:0] fin_phase;
    logic    open_rec;
    logic    emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    letter_e letter;
    logic    g_big;
    logic    g_neg;
  } sts_t;

  function automatic letter_e letter_of(input logic [7:0] c);
    letter_e r;
    r = LET_NONE;
    unique case (c)
      8'h47: r = LET_G;
      8'h58: r = LET_X;
      8'h59: r = LET_Y;
      8'h5A: r = LET_Z;
      8'h49: r = LET_I;
      8'h4A: r = LET_J;
      default: r = LET_NONE;
    endcase
    return r;
  endfunction

endpackage

@@ design/gclp_datapath.sv @@
// Datapath of the G-code line field parser: number accumulation and fixed-point conversion.
module gclp_datapath #(
  parameter int MaxFrac = 6
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  gclp_pkg::cmd_t cmd_i,
  output gclp_pkg::sts_t sts_o,
  input  logic [31:0] scale_i,
  input  logic signed [31:0] offx_i,
  input  logic signed [31:0] offy_i,
  input  logic signed [31:0] initx_i,
  input  logic signed [31:0] inity_i,
  output logic [3:0] gcmd_o,
  output logic [31:0] v_o [5]
);
  import gclp_pkg::*;

  localparam int FracCap = (MaxFrac > 9) ? 9 : MaxFrac;

  letter_e let_q;
  logic [39:0] mant_q;
  logic [29:0] frac_q;
  logic [3:0] nfrac_q;
  logic neg_q, fx_q;
  logic [3:0] gcmd_q;
  logic [31:0] val_q [5];
  logic [56:0] mag_q;
  logic [63:0] prod_q;
  logic [31:0] p_hi_q;
  logic ovf_q;
  logic [46:0] quot_q;
  logic [45:0] rem_q;
  logic [29:0] den_q;
  logic [5:0] dcnt_q;

  function automatic logic [29:0] pow10(input logic [3:0] k);
    logic [29:0] r;
    r = 30'd1;
    for (int i = 0; i < 9; i++) begin
      if (i < k) r = 30'(r * 30'd10);
    end
    return r;
  endfunction

  logic [43:0] mant_mul;
  logic [46:0] rem_try;
  logic [31:0] mul_a;
  logic [63:0] mulop;
  logic [48:0] sres;
  logic signed [50:0] sv;
  logic signed [31:0] off_sel;
  logic signed [58:0] zv;

  function automatic logic [31:0] sat(input logic signed [58:0] v);
    logic [31:0] r;
    if (v > 59'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -59'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Phase 1 multiplies the high half of the magnitude, phase 2 the low half.
  always_comb begin
    mant_mul = {mant_q, 3'b0} + {2'b0, mant_q, 1'b0} + 44'(cmd_i.digit);
    rem_try = {rem_q, quot_q[46]} - {17'd0, den_q};
    mul_a = (cmd_i.fin_phase == 3'd1) ? {7'd0, mag_q[56:32]} : mag_q[31:0];
    mulop = {32'd0, mul_a} * {32'd0, scale_i};
    sres = {1'b0, p_hi_q, 16'd0} + {1'b0, prod_q[63:16]};
    off_sel = (let_q == LET_Y || let_q == LET_J) ? offy_i : offx_i;
    if (ovf_q) sv = neg_q ? -51'sd1099511627776 : 51'sd1099511627776;
    else sv = neg_q ? -$signed({2'b0, sres}) : $signed({2'b0, sres});
    zv = neg_q ? -$signed({2'b0, mag_q}) : $signed({2'b0, mag_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      let_q <= LET_NONE; mant_q <= '0; frac_q <= '0; nfrac_q <= '0; neg_q <= 1'b0;
      fx_q <= 1'b0; gcmd_q <= '0;
      for (int i = 0; i < 5; i++) val_q[i] <= '0;
      mag_q <= '0; prod_q <= '0; p_hi_q <= '0; ovf_q <= 1'b0; quot_q <= '0; rem_q <= '0;
      den_q <= 30'd1; dcnt_q <= '0;
    end else begin
      if (cmd_i.open_rec && !fx_q) begin
        val_q[0] <= initx_i; val_q[1] <= inity_i;
      end
      if (cmd_i.start_letter) begin
        let_q <= cmd_i.letter; mant_q <= '0; frac_q <= '0; nfrac_q <= '0; neg_q <= 1'b0;
      end
      if (cmd_i.set_neg) neg_q <= cmd_i.neg_val;
      if (cmd_i.int_digit) mant_q <= (mant_mul > {4'd0, INT_CAP}) ? INT_CAP : mant_mul[39:0];
      if (cmd_i.frac_digit && nfrac_q < 4'(FracCap)) begin
        frac_q <= 30'(frac_q * 30'd10 + 30'(cmd_i.digit));
        nfrac_q <= nfrac_q + 4'd1;
      end
      if (cmd_i.fin_start) begin
        quot_q <= {1'b0, frac_q, 16'd0}; rem_q <= '0; den_q <= pow10(nfrac_q);
        dcnt_q <= 6'd47;
      end else if (dcnt_q != 6'd0) begin
        dcnt_q <= dcnt_q - 6'd1;
        if (!rem_try[46]) begin
          rem_q <= rem_try[45:0]; quot_q <= {quot_q[45:0], 1'b1};
        end else begin
          rem_q <= {rem_q[44:0], quot_q[46]}; quot_q <= {quot_q[45:0], 1'b0};
        end
      end
      if (cmd_i.fin_step) begin
        unique case (cmd_i.fin_phase)
          3'd0: mag_q <= {1'b0, mant_q, 16'd0} + {10'd0, quot_q};
          3'd1: prod_q <= mulop;
          3'd2: begin
            p_hi_q <= prod_q[31:0]; ovf_q <= prod_q[63:32] != 32'd0; prod_q <= mulop;
          end
          3'd3: begin
            unique case (let_q)
              LET_G: begin
                if (!(neg_q && mant_q != '0)) gcmd_q <= mant_q[3:0];
                if ((neg_q && mant_q != '0) || mant_q > 40'(MAX_GCMD)) gcmd_q <= 4'hF;
              end
              LET_X: begin val_q[0] <= sat(59'(sv) + 59'(off_sel)); fx_q <= 1'b1; end
              LET_Y: val_q[1] <= sat(59'(sv) + 59'(off_sel));
              LET_Z: val_q[2] <= sat(zv);
              LET_I: val_q[3] <= sat(59'(sv) + 59'(off_sel));
              LET_J: val_q[4] <= sat(59'(sv) + 59'(off_sel));
              default: ;
            endcase
            let_q <= LET_NONE;
          end
          default: ;
        endcase
      end
    end
  end

  assign sts_o.letter = let_q;
  assign sts_o.g_big = mant_q > 40'(MAX_GCMD);
  assign sts_o.g_neg = neg_q && mant_q != '0;
  assign gcmd_o = gcmd_q;

  // A record that opens on its own newline reports the initial point at once.
  always_comb begin
    for (int i = 0; i < 5; i++) v_o[i] = val_q[i];
    if (cmd_i.open_rec && !fx_q) begin
      v_o[0] = initx_i; v_o[1] = inity_i;
    end
  end
  logic unused;
  assign unused = cmd_i.emit;
endmodule

@@ design/gclp_ctrl.sv @@
// Controller state machine of the G-code line field parser.
module gclp_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [7:0] char_i,
  input  logic out_full_i,
  input  gclp_pkg::sts_t sts_i,
  output gclp_pkg::cmd_t cmd_o
);
  import gclp_pkg::*;

  localparam logic [2:0] M_IDLE = 3'd0, M_COMM = 3'd1, M_PRE = 3'd2, M_SIGN = 3'd3,
                         M_INT = 3'd4, M_FRAC = 3'd5;
  localparam logic [1:0] S_RUN = 2'd0, S_DIV = 2'd1, S_FIN = 2'd2;

  logic [1:0] st_q, st_d;
  logic [2:0] mode_q, mode_d;
  logic skip_q, skip_d, open_q, open_d;
  logic [7:0] ch_q, ch_d;
  logic [5:0] cnt_q, cnt_d;
  logic [2:0] ph_q, ph_d;
  logic pend_q, pend_d;

  logic digit, is_num, ws;
  letter_e lc;

  always_comb begin
    cmd_o = '0;
    st_d = st_q; mode_d = mode_q; skip_d = skip_q; open_d = open_q; ch_d = ch_q;
    cnt_d = cnt_q; ph_d = ph_q; pend_d = pend_q;
    in_ready_o = 1'b0;
    digit = ch_q >= 8'h30 && ch_q <= 8'h39;
    ws = ch_q == 8'h20 || ch_q == 8'h09 || ch_q == 8'h0D || ch_q == 8'h0B || ch_q == 8'h0C;
    lc = letter_of(ch_q);
    cmd_o.digit = ch_q[3:0];
    is_num = 1'b0;
    unique case (st_q)
      S_RUN: begin
        in_ready_o = !pend_q && !out_full_i;
        if (pend_q) begin
          pend_d = 1'b0;
          if (!open_q) begin open_d = 1'b1; cmd_o.open_rec = 1'b1; end
          if (ch_q == CH_NL) begin
            if (mode_q >= M_PRE) begin
              cmd_o.fin_start = 1'b1; st_d = S_DIV; cnt_d = 6'd48; ph_d = 3'd0;
            end else if (skip_q) begin
              skip_d = 1'b0; mode_d = M_IDLE;
            end else begin
              mode_d = M_IDLE; cmd_o.emit = 1'b1; open_d = 1'b0;
            end
          end else if (!skip_q) begin
            if (mode_q == M_COMM) begin
              if (ch_q == CH_RPAR) mode_d = M_IDLE;
            end else begin
              if (mode_q >= M_PRE) begin
                if (mode_q == M_PRE && ws) is_num = 1'b1;
                else if (mode_q == M_PRE && (ch_q == 8'h2B || ch_q == 8'h2D)) begin
                  is_num = 1'b1; cmd_o.set_neg = 1'b1; cmd_o.neg_val = ch_q == 8'h2D;
                  mode_d = M_SIGN;
                end else if (mode_q != M_FRAC && digit) begin
                  is_num = 1'b1; cmd_o.int_digit = 1'b1; mode_d = M_INT;
                end else if (mode_q != M_FRAC && ch_q == 8'h2E && sts_i.letter != LET_G) begin
                  is_num = 1'b1; mode_d = M_FRAC;
                end else if (mode_q == M_FRAC && digit) begin
                  is_num = 1'b1; cmd_o.frac_digit = 1'b1;
                end
                if (!is_num) begin
                  cmd_o.fin_start = 1'b1; st_d = S_DIV; cnt_d = 6'd48; ph_d = 3'd0;
                end
              end else if (ch_q == CH_LPAR) mode_d = M_COMM;
              else if (lc != LET_NONE) begin
                cmd_o.start_letter = 1'b1; cmd_o.letter = lc; mode_d = M_PRE;
              end
            end
          end
        end else if (in_valid_i && !out_full_i) begin
          ch_d = char_i; pend_d = 1'b1;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) st_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin_step = 1'b1; cmd_o.fin_phase = ph_q; ph_d = ph_q + 3'd1;
        if (ph_q == 3'd3) begin
          st_d = S_RUN; mode_d = M_IDLE;
          if (sts_i.letter == LET_G && !sts_i.g_neg && sts_i.g_big) skip_d = 1'b1;
          // Replay the terminating character as ordinary text, unless an out-of-range G number drops it.
          pend_d = 1'b1;
          if (ch_q != CH_NL && sts_i.letter == LET_G && !sts_i.g_neg && sts_i.g_big)
            pend_d = 1'b0;
        end
      end
      default: st_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_RUN; mode_q <= M_IDLE; skip_q <= 1'b0; open_q <= 1'b0; ch_q <= '0;
      cnt_q <= '0; ph_q <= '0; pend_q <= 1'b0;
    end else begin
      st_q <= st_d; mode_q <= mode_d; skip_q <= skip_d; open_q <= open_d; ch_q <= ch_d;
      cnt_q <= cnt_d; ph_q <= ph_d; pend_q <= pend_d;
    end
  end
endmodule

@@ design/gcode_line_field_parser_core.sv @@
// Top level of the G-code line field parser.
// Each character is taken, then processed before the next one is accepted. A character
// that ends a number first runs the fraction divider and the four finishing steps; after an
// out-of-range G number it is dropped unless it is a newline. A record word is registered
// once its newline is processed, after those steps if it ends a number, and held until taken.
// Reset clears parse state and out_valid_o and restores config defaults; output data is kept.
module gcode_line_field_parser_core #(
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [7:0] char_in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [3:0] gcommand_o,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic signed [31:0] z_out_o,
  output logic signed [31:0] i_out_o,
  output logic signed [31:0] j_out_o,
  input  logic cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import gclp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [31:0] scale_q, offx_q, offy_q, initx_q, inity_q;
  logic [3:0] gcmd;
  logic [31:0] v [5];
  logic ov_q;
  logic [3:0] og_q;
  logic [31:0] ox_q, oy_q, oz_q, oi_q, oj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 32'd65536; offx_q <= '0; offy_q <= '0; initx_q <= '0; inity_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE: scale_q <= cfg_data_i;
        CFG_OFFX:  offx_q <= cfg_data_i;
        CFG_OFFY:  offy_q <= cfg_data_i;
        CFG_INITX: initx_q <= cfg_data_i;
        CFG_INITY: inity_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gclp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .char_i(char_in_i),
    .out_full_i(ov_q), .sts_i(sts), .cmd_o(cmd)
  );

  gclp_datapath #(.MaxFrac(MAX_FRAC_DIGITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .scale_i(scale_q),
    .offx_i(offx_q), .offy_i(offy_q), .initx_i(initx_q), .inity_i(inity_q),
    .gcmd_o(gcmd), .v_o(v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd.emit) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      og_q <= gcmd; ox_q <= v[0]; oy_q <= v[1]; oz_q <= v[2]; oi_q <= v[3]; oj_q <= v[4];
    end
  end

  assign out_valid_o = ov_q;
  assign gcommand_o = og_q;
  assign x_out_o = ox_q;
  assign y_out_o = oy_q;
  assign z_out_o = oz_q;
  assign i_out_o = oi_q;
  assign j_out_o = oj_q;

  a_emit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !ov_q) else $error("record emitted over an untaken word");
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !in_ready_o) else $error("input taken while output full");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(ox_q)) else $error("output word lost");
endmodule
